// ===== rtl/core/pinhole_roi_point_filter_defines.svh =====
// Assertion macros for the pinhole ROI point filter checker.
// Used by the checker file only; expects clk_i and rst_ni in scope.
`ifndef PINHOLE_ROI_POINT_FILTER_DEFINES_SVH
`define PINHOLE_ROI_POINT_FILTER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/prf_pkg.sv =====
// Shared types, constants and codes of the pinhole ROI point filter.
// No dependencies; every module of the block refers to it by scoped names.
`default_nettype none

package prf_pkg;

  localparam int IMAGE_WIDTH  = 640;
  localparam int IMAGE_HEIGHT = 480;
  localparam int COUNT_BITS   = 20;

  localparam int COORD_W   = 32;
  localparam int COLOR_W   = 24;
  localparam int PIX_W     = 16;
  localparam int TOTAL_W   = 20;
  localparam int BOX_W     = 13;
  localparam int BND_W     = 15;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam int MUL_A_W  = COORD_W + 1;
  localparam int MUL_B_W  = 27;
  localparam int NUM_W    = MUL_A_W + MUL_B_W;
  localparam int QUO_BITS = PIX_W - 1;

  // Q16.16 intrinsics and the Q16.16 x offset
  localparam logic signed [MUL_B_W-1:0] FX_Q16   = 27'sd39619936;
  localparam logic signed [MUL_B_W-1:0] FY_Q16   = 27'sd39640556;
  localparam logic signed [MUL_B_W-1:0] CX_Q16   = 27'sd21538232;
  localparam logic signed [MUL_B_W-1:0] CY_Q16   = 27'sd16216372;
  localparam logic signed [MUL_A_W-1:0] XOFF_Q16 = 33'sd983;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X1  = 3'd0,
    CFG_BOX_Y1  = 3'd1,
    CFG_BOX_X2  = 3'd2,
    CFG_BOX_Y2  = 3'd3,
    CFG_BOX_SET = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_C,
    S_MUL_P,
    S_SUM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic        [COLOR_W-1:0] color;
    logic                      finite;
    logic                      last_in_cloud;
  } point_in_t;

  typedef struct packed {
    logic                      keep;
    logic signed [PIX_W-1:0]   pixel_u;
    logic signed [PIX_W-1:0]   pixel_v;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic        [COLOR_W-1:0] out_color;
    logic        [TOTAL_W-1:0] kept_total;
    logic                      end_of_cloud;
    logic                      publish;
  } point_out_t;

  typedef struct packed {
    logic                    box_set;
    logic signed [BND_W-1:0] left;
    logic signed [BND_W-1:0] right;
    logic signed [BND_W-1:0] top;
    logic signed [BND_W-1:0] bottom;
  } box_bnd_t;

  typedef struct packed {
    logic                  done;
    logic signed [PIX_W-1:0] quo;
  } div_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/prf_box.sv =====
// Box registers and the shrunk, image-clamped bounds derived from them.
// Depends on prf_pkg.
`default_nettype none

module prf_box (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  prf_pkg::cfg_idx_e  cfg_index_i,
  input  logic [prf_pkg::BOX_W-1:0] cfg_data_i,
  output prf_pkg::box_bnd_t  bnd_o
);

  localparam int AW = prf_pkg::BOX_W;
  localparam int SW = prf_pkg::BOX_W + 1;
  localparam int BW = prf_pkg::BND_W;
  localparam logic signed [BW-1:0] X_LIM = BW'(prf_pkg::IMAGE_WIDTH - 1);
  localparam logic signed [BW-1:0] Y_LIM = BW'(prf_pkg::IMAGE_HEIGHT - 1);

  logic signed [AW-1:0] x1_q, y1_q, x2_q, y2_q;
  logic                 set_q;
  prf_pkg::box_bnd_t    bnd_d, bnd_q;

  // Half-size box about the center, truncating divisions toward zero
  function automatic logic [2*BW-1:0] shrink(input logic signed [AW-1:0] a,
                                             input logic signed [AW-1:0] b,
                                             input logic signed [BW-1:0] lim);
    logic signed [SW-1:0] s, d, c, h;
    logic signed [BW-1:0] lo, hi;
    s = SW'(a) + SW'(b);
    c = s >>> 1;
    if (s[SW-1] && s[0]) c = c + 1'b1;
    d = SW'(b) - SW'(a);
    h = d >>> 2;
    if (d[SW-1] && (d[1:0] != 2'b00)) h = h + 1'b1;
    lo = BW'(c) - BW'(h);
    hi = BW'(c) + BW'(h);
    if (lo < 0) lo = '0;
    if (hi > lim) hi = lim;
    return {lo, hi};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q  <= '0;
      y1_q  <= '0;
      x2_q  <= '0;
      y2_q  <= '0;
      set_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        prf_pkg::CFG_BOX_X1:  x1_q  <= cfg_data_i;
        prf_pkg::CFG_BOX_Y1:  y1_q  <= cfg_data_i;
        prf_pkg::CFG_BOX_X2:  x2_q  <= cfg_data_i;
        prf_pkg::CFG_BOX_Y2:  y2_q  <= cfg_data_i;
        prf_pkg::CFG_BOX_SET: set_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bnd_d.box_set = set_q;
    {bnd_d.left, bnd_d.right}  = shrink(x1_q, x2_q, X_LIM);
    {bnd_d.top, bnd_d.bottom}  = shrink(y1_q, y2_q, Y_LIM);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_q <= '0;
    end else begin
      bnd_q <= bnd_d;
    end
  end

  assign bnd_o = bnd_q;

endmodule

`default_nettype wire

// ===== rtl/core/prf_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on prf_pkg for operand widths.
`default_nettype none

module prf_mul (
  input  logic                               clk_i,
  input  logic signed [prf_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [prf_pkg::MUL_B_W-1:0] b_i,
  output logic signed [prf_pkg::NUM_W-1:0]   prod_o
);

  logic signed [prf_pkg::NUM_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== rtl/core/prf_div.sv =====
// Bit-serial restoring divider: one quotient bit a cycle, saturating to PIX_W.
// Depends on prf_pkg; divides num by den * 2^FRAC_W, truncating toward zero.
`default_nettype none

module prf_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [prf_pkg::NUM_W-1:0]   num_i,
  input  logic signed [prf_pkg::COORD_W-1:0] den_i,
  output prf_pkg::div_res_t                  res_o
);

  localparam int NW = prf_pkg::NUM_W;
  localparam int DW = prf_pkg::COORD_W;
  localparam int QB = prf_pkg::QUO_BITS;
  localparam int PW = prf_pkg::PIX_W;
  localparam int SW = DW + prf_pkg::FRAC_W + QB - 1;
  localparam int TW = SW + 1;
  localparam int CW = $clog2(QB);
  localparam logic [CW-1:0] LAST_STEP = CW'(QB - 1);
  localparam logic [PW-1:0] Q_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic [PW-1:0] Q_MIN = {1'b1, {(PW-1){1'b0}}};

  logic [NW-1:0] num_mag;
  logic [DW-1:0] den_mag;
  logic          sat_d;
  logic          ge;

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] rem_q, dsr_q;
  logic [QB-1:0] quo_q;
  logic          neg_q, sat_q;

  assign num_mag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  assign den_mag = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
  assign sat_d   = TW'(num_mag) >= (TW'(den_mag) << (prf_pkg::FRAC_W + QB));
  assign ge      = rem_q >= dsr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= SW'(num_mag);
      dsr_q <= SW'(den_mag) << (prf_pkg::FRAC_W + QB - 1);
      quo_q <= '0;
      neg_q <= num_i[NW-1] ^ den_i[DW-1];
      sat_q <= sat_d;
    end else if (busy_q) begin
      rem_q <= ge ? rem_q - dsr_q : rem_q;
      dsr_q <= dsr_q >> 1;
      quo_q <= {quo_q[QB-2:0], ge};
    end
  end

  always_comb begin
    res_o.done = done_q;
    if (sat_q) begin
      res_o.quo = neg_q ? Q_MIN : Q_MAX;
    end else begin
      res_o.quo = neg_q ? -(PW'(quo_q)) : PW'(quo_q);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pinhole_roi_point_filter.sv =====
// Top level of the pinhole ROI point filter: sequencer, count and result register.
// Depends on prf_pkg, prf_box, prf_mul and prf_div.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one 3D point a beat.
//   Output channel (out_valid_o / out_stall_i / out_data_o) gives one result beat
//   per point, in order: projected pixel, keep flag, passthrough fields and the
//   running kept count, with publish on the last point of a cloud that kept any.
//   Config channel (cfg_valid_i / cfg_ready_o) writes the box registers; it is
//   always ready. Write it only while no point is in flight.
//   Timing: one shared multiplier and one bit-serial divider do the work. Each
//   coordinate passes through S_MUL_C and S_MUL_P (multiply), S_SUM, S_DIV_GO
//   (divider load) and S_DIV_WAIT, then the point goes to S_OUT; a point with
//   zero depth skips the projection and goes from S_MUL_C straight to S_OUT.
//   The input stalls while a point is in work; a result waiting in the output
//   register does not block the next point, which holds only at its own end.
//   Reset clears the sequencer, the kept count, the output valid and the box
//   registers (box_set 0: nothing is kept until a box is written).
`default_nettype none

module pinhole_roi_point_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  prf_pkg::point_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output prf_pkg::point_out_t        out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  prf_pkg::cfg_idx_e          cfg_index_i,
  input  logic [prf_pkg::BOX_W-1:0]  cfg_data_i
);

  localparam int CB    = prf_pkg::COUNT_BITS;
  localparam int CMP_W = prf_pkg::PIX_W + 1;
  localparam int CW    = prf_pkg::COORD_W;
  localparam logic [CB-1:0] CNT_MAX = '1;

  prf_pkg::state_e     state_q, state_d;
  logic                phase_q, phase_d;   // 0: column, 1: row
  prf_pkg::point_in_t  pt_q;
  logic signed [prf_pkg::NUM_W-1:0] acc_q, acc_d;
  logic signed [prf_pkg::PIX_W-1:0] u_q, u_d, v_q, v_d;
  logic [CB-1:0]       count_q, count_d, cnt_inc;
  prf_pkg::point_out_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic signed [prf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [prf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [prf_pkg::NUM_W-1:0]   prod;
  logic                               div_start;
  prf_pkg::div_res_t                  div_res;
  prf_pkg::box_bnd_t                  bnd;

  logic                    z_zero, keep_w, in_acc;
  logic signed [CMP_W-1:0] u_c, v_c, l_c, r_c, t_c, b_c;

  prf_box u_box (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .bnd_o       (bnd)
  );

  prf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  prf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_q),
    .den_i   (pt_q.point_z),
    .res_o   (div_res)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != prf_pkg::S_IDLE);
  assign in_acc      = in_valid_i && (state_q == prf_pkg::S_IDLE);
  assign z_zero      = (pt_q.point_z == '0);

  // Feed the shared multiplier: coordinate times focal, then center times depth
  always_comb begin
    mul_a = {pt_q.point_z[CW-1], pt_q.point_z};
    mul_b = phase_q ? prf_pkg::CY_Q16 : prf_pkg::CX_Q16;
    if (state_q == prf_pkg::S_MUL_C) begin
      if (phase_q) begin
        mul_a = {pt_q.point_y[CW-1], pt_q.point_y};
        mul_b = prf_pkg::FY_Q16;
      end else begin
        mul_a = {pt_q.point_x[CW-1], pt_q.point_x} + prf_pkg::XOFF_Q16;
        mul_b = prf_pkg::FX_Q16;
      end
    end
  end

  // Box test on the finished pixel
  assign u_c = CMP_W'(u_q);
  assign v_c = CMP_W'(v_q);
  assign l_c = CMP_W'($signed(bnd.left));
  assign r_c = CMP_W'($signed(bnd.right));
  assign t_c = CMP_W'($signed(bnd.top));
  assign b_c = CMP_W'($signed(bnd.bottom));
  assign keep_w = pt_q.finite && !z_zero && bnd.box_set &&
                  (u_c >= l_c) && (u_c <= r_c) && (v_c >= t_c) && (v_c <= b_c);

  // Saturating count including this point
  assign cnt_inc = (keep_w && (count_q != CNT_MAX)) ? count_q + CB'(1) : count_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    acc_d       = acc_q;
    u_d         = u_q;
    v_d         = v_q;
    count_d     = count_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_start   = 1'b0;
    unique case (state_q)
      prf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = prf_pkg::S_MUL_C;
          phase_d = 1'b0;
        end
      end
      prf_pkg::S_MUL_C: begin
        // Zero depth: no projection, pixel reads as zero
        if (z_zero) begin
          u_d     = '0;
          v_d     = '0;
          state_d = prf_pkg::S_OUT;
        end else begin
          state_d = prf_pkg::S_MUL_P;
        end
      end
      prf_pkg::S_MUL_P: begin
        acc_d   = prod;
        state_d = prf_pkg::S_SUM;
      end
      prf_pkg::S_SUM: begin
        acc_d   = acc_q + prod;
        state_d = prf_pkg::S_DIV_GO;
      end
      prf_pkg::S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = prf_pkg::S_DIV_WAIT;
      end
      prf_pkg::S_DIV_WAIT: begin
        if (div_res.done) begin
          if (!phase_q) begin
            u_d     = div_res.quo;
            phase_d = 1'b1;
            state_d = prf_pkg::S_MUL_C;
          end else begin
            v_d     = div_res.quo;
            state_d = prf_pkg::S_OUT;
          end
        end
      end
      prf_pkg::S_OUT: begin
        // Hold until the output register is free, then load the beat
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.keep         = keep_w;
          out_d.pixel_u      = u_q;
          out_d.pixel_v      = v_q;
          out_d.out_x        = pt_q.point_x;
          out_d.out_y        = pt_q.point_y;
          out_d.out_z        = pt_q.point_z;
          out_d.out_color    = pt_q.color;
          out_d.kept_total   = prf_pkg::TOTAL_W'(cnt_inc);
          out_d.end_of_cloud = pt_q.last_in_cloud;
          out_d.publish      = pt_q.last_in_cloud && (cnt_inc != '0);
          count_d            = pt_q.last_in_cloud ? '0 : cnt_inc;
          state_d            = prf_pkg::S_IDLE;
        end
      end
      default: state_d = prf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prf_pkg::S_IDLE;
      phase_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) pt_q <= in_data_i;
    acc_q <= acc_d;
    u_q   <= u_d;
    v_q   <= v_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/prf_checker.sv =====
// Port-level checker for the pinhole ROI point filter, bound to the top level.
// Depends on prf_pkg and the assertion macros header.
`default_nettype none

`include "pinhole_roi_point_filter_defines.svh"

module prf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input prf_pkg::point_out_t out_data_o
);

  // Stalled result beat holds
  `PRF_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  // Accepted point keeps the block busy on the next cycle
  `PRF_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "not busy after accept")

  // A new result comes only out of work in progress
  `PRF_ASSERT(a_result_from_work, $rose(out_valid_o) |-> $past(in_stall_o), "result without work")

  // Reset seen at an edge leaves both channels quiet on the next cycle
  `PRF_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o && !in_stall_o, "activity in reset")

endmodule

bind pinhole_roi_point_filter prf_checker u_prf_checker (.*);

`default_nettype wire

// ===== test/prf_point_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the pinhole ROI point filter: mirrors the box registers,
// predicts every result beat and compares it field by field with the block.
// Depends on prf_pkg for the beat structs, register codes and intrinsics.
module prf_point_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  prf_pkg::point_in_t        in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  prf_pkg::point_out_t       out_data_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  prf_pkg::cfg_idx_e         cfg_index_i,
  input  logic [prf_pkg::BOX_W-1:0] cfg_data_i,
  output int                        mismatch_count_o,
  output int                        pending_o
);
  import prf_pkg::*;

  localparam longint PIX_MAX   = 32767;
  localparam longint PIX_MIN   = -32768;
  localparam int     EXP_DEPTH = 16;

  logic signed [BOX_W-1:0] box_x1, box_y1, box_x2, box_y2;
  logic                    box_set;
  logic [COUNT_BITS-1:0]   kept_count;
  point_out_t              expected_points[EXP_DEPTH];
  int                      exp_head = 0;
  int                      exp_tail = 0;
  int                      exp_count = 0;
  int                      mismatch_count = 0;

  // Exact rational projection, truncated toward zero once, then saturated.
  function automatic longint pixel_coord(longint c, longint z, longint f, longint p);
    longint q;
    q = (c * f + p * z) / (z * (longint'(1) << FRAC_W));
    if (q > PIX_MAX) q = PIX_MAX;
    else if (q < PIX_MIN) q = PIX_MIN;
    return q;
  endfunction

  // Half-size box about its center, clamped to [0, lim].
  function automatic void shrink_span(input longint a, input longint b, input longint lim,
                                      output longint lo, output longint hi);
    longint mid, half;
    mid  = (a + b) / 2;
    half = ((b - a) / 2) / 2;
    lo   = mid - half;
    hi   = mid + half;
    if (lo < 0) lo = 0;
    if (hi > lim) hi = lim;
  endfunction

  // Predict one result and advance the kept count.
  function automatic point_out_t filter_point(point_in_t p);
    point_out_t r;
    longint     x, y, z, u, v, lft, rgt, top_row, bot_row;
    logic       is_kept;
    x = $signed(p.point_x);
    y = $signed(p.point_y);
    z = $signed(p.point_z);
    u = 0;
    v = 0;
    is_kept = 1'b0;
    if (z != 0) begin
      u = pixel_coord(x + longint'(XOFF_Q16), z, longint'(FX_Q16), longint'(CX_Q16));
      v = pixel_coord(y, z, longint'(FY_Q16), longint'(CY_Q16));
    end
    if (p.finite && z != 0 && box_set) begin
      shrink_span(longint'(box_x1), longint'(box_x2), IMAGE_WIDTH - 1, lft, rgt);
      shrink_span(longint'(box_y1), longint'(box_y2), IMAGE_HEIGHT - 1, top_row, bot_row);
      is_kept = (u >= lft) && (u <= rgt) && (v >= top_row) && (v <= bot_row);
    end
    if (is_kept && kept_count != '1) kept_count = kept_count + 1'b1;
    r.keep         = is_kept;
    r.pixel_u      = PIX_W'(u);
    r.pixel_v      = PIX_W'(v);
    r.out_x        = p.point_x;
    r.out_y        = p.point_y;
    r.out_z        = p.point_z;
    r.out_color    = p.color;
    r.kept_total   = TOTAL_W'(kept_count);
    r.end_of_cloud = p.last_in_cloud;
    r.publish      = p.last_in_cloud && (kept_count != '0);
    if (p.last_in_cloud) kept_count = '0;
    return r;
  endfunction

  // Append one predicted beat to the ring of outstanding results.
  task automatic push_expected(input point_out_t item);
    if (exp_count == EXP_DEPTH) begin
      $error("too many results outstanding");
      mismatch_count++;
    end else begin
      expected_points[exp_tail] = item;
      exp_tail = (exp_tail + 1) % EXP_DEPTH;
      exp_count++;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_out_t want;
    if (!rst_ni) begin
      box_x1     = '0;
      box_y1     = '0;
      box_x2     = '0;
      box_y2     = '0;
      box_set    = 1'b0;
      kept_count = '0;
      exp_head   = 0;
      exp_tail   = 0;
      exp_count  = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BOX_X1:  box_x1  = cfg_data_i;
          CFG_BOX_Y1:  box_y1  = cfg_data_i;
          CFG_BOX_X2:  box_x2  = cfg_data_i;
          CFG_BOX_Y2:  box_y2  = cfg_data_i;
          CFG_BOX_SET: box_set = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (exp_count == 0) begin
          $error("result beat with no point outstanding");
          mismatch_count++;
        end else begin
          want = expected_points[exp_head];
          exp_head = (exp_head + 1) % EXP_DEPTH;
          exp_count--;
          check_field("keep", want.keep, out_data_i.keep);
          check_field("pixel_u", want.pixel_u, out_data_i.pixel_u);
          check_field("pixel_v", want.pixel_v, out_data_i.pixel_v);
          check_field("out_x", want.out_x, out_data_i.out_x);
          check_field("out_y", want.out_y, out_data_i.out_y);
          check_field("out_z", want.out_z, out_data_i.out_z);
          check_field("out_color", want.out_color, out_data_i.out_color);
          check_field("kept_total", want.kept_total, out_data_i.kept_total);
          check_field("end_of_cloud", want.end_of_cloud, out_data_i.end_of_cloud);
          check_field("publish", want.publish, out_data_i.publish);
        end
      end
      if (in_valid_i && !in_stall_i) push_expected(filter_point(in_data_i));
      mismatch_count_o <= mismatch_count;
      pending_o        <= exp_count;
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the pinhole ROI point filter test: clock, reset, stimulus and verdict.
// Depends on prf_pkg, the block itself and prf_point_checker.
module testbench;
  import prf_pkg::*;

  localparam longint COORD_MAX     = 64'sd2147483647;
  localparam longint COORD_MIN     = -64'sd2147483648;
  localparam longint ONE_METRE     = 65536;
  localparam int     SETTLE_CYCLES = 48;
  localparam int     PHASES        = 8;
  localparam int     PHASE_POINTS  = 175;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  point_in_t   in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  point_out_t  out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_e    cfg_index = CFG_BOX_X1;
  logic [BOX_W-1:0] cfg_data = '0;

  int mismatches;
  int pending;

  // Drop all idling on both sides while set, for back-to-back stretches.
  bit no_idle = 1'b0;

  int points_sent  = 0;
  int clouds_sent  = 0;
  int box_settings = 0;

  pinhole_roi_point_filter u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  prf_point_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("pinhole_roi_point_filter: mismatch");
    $finish;
  end

  // Receiver: stall for a random number of cycles, then take exactly one beat.
  initial begin
    int hold;
    wait (rst_n);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Present one register write and hold it until taken; valid stays high
  // so back-to-back writes never lower and raise it in one step.
  task automatic write_reg(input cfg_idx_e idx, input logic [BOX_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  // Write all box registers; sometimes tack on a write to an unused index.
  task automatic program_box(input int x1, input int y1, input int x2, input int y2,
                             input bit set_box);
    logic [BOX_W-1:0] set_word;
    set_word    = BOX_W'($urandom);
    set_word[0] = set_box;
    write_reg(CFG_BOX_X1, BOX_W'(x1));
    write_reg(CFG_BOX_Y1, BOX_W'(y1));
    write_reg(CFG_BOX_X2, BOX_W'(x2));
    write_reg(CFG_BOX_Y2, BOX_W'(y2));
    write_reg(CFG_BOX_SET, set_word);
    if ($urandom_range(0, 3) == 0)
      write_reg(cfg_idx_e'(int'(CFG_BOX_SET) + $urandom_range(1, 3)), BOX_W'($urandom));
    cfg_valid <= 1'b0;
    box_settings++;
  endtask

  // Wait out a random gap, then present the point and hold it until taken.
  task automatic send_point(input point_in_t p);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!(in_valid && !in_stall));
    points_sent++;
    if (p.last_in_cloud) clouds_sent++;
  endtask

  // Stop sending and hold off until every outstanding result has come back.
  // The first edge lets the checker's count catch up with the last beat.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic point_in_t make_point(longint x, longint y, longint z, bit fin, bit last);
    point_in_t p;
    p.point_x       = COORD_W'(x);
    p.point_y       = COORD_W'(y);
    p.point_z       = COORD_W'(z);
    p.color         = COLOR_W'($urandom);
    p.finite        = fin;
    p.last_in_cloud = last;
    return p;
  endfunction

  // Back-project a target pixel at a random depth, with a little jitter on x and y,
  // so the point lands on or near that pixel.
  function automatic point_in_t aimed_point(int u_t, int v_t, bit last);
    longint x, y, z;
    z = $urandom_range(19661, 655360);
    x = ((longint'(u_t) * ONE_METRE - longint'(CX_Q16)) * z) / longint'(FX_Q16)
        - longint'(XOFF_Q16) + longint'($urandom_range(0, 200)) - 100;
    y = ((longint'(v_t) * ONE_METRE - longint'(CY_Q16)) * z) / longint'(FY_Q16)
        + longint'($urandom_range(0, 200)) - 100;
    return make_point(x, y, z, $urandom_range(0, 9) != 0, last);
  endfunction

  // Coordinates from the corners of the range: zero and tiny depth, saturation.
  function automatic point_in_t edge_point(bit last);
    longint corner[7] = '{0, 1, -1, ONE_METRE, -ONE_METRE, COORD_MAX, COORD_MIN};
    return make_point(corner[$urandom_range(0, 6)], corner[$urandom_range(0, 6)],
                      corner[$urandom_range(0, 6)], $urandom_range(0, 1), last);
  endfunction

  initial begin
    point_in_t p;
    int        cloud_left;
    int        sel;
    int        bx;
    int        by;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: box 100..540 x 80..400 shrinks to columns 210..430, rows 160..320.
    program_box(100, 80, 540, 400, 1'b1);
    p = make_point(0, 0, ONE_METRE, 1'b1, 1'b0);
    p.color = '0;
    send_point(p);
    p = make_point(0, 0, ONE_METRE, 1'b0, 1'b0);
    p.color = '1;
    send_point(p);
    send_point(make_point(COORD_MAX, COORD_MAX, 0, 1'b1, 1'b0));
    send_point(make_point(0, 0, 1, 1'b1, 1'b0));
    send_point(make_point(COORD_MIN, COORD_MIN, 1, 1'b1, 1'b0));
    send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0));
    send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0));
    send_point(make_point(COORD_MIN, COORD_MAX, -ONE_METRE, 1'b1, 1'b0));
    send_point(aimed_point(320, 240, 1'b0));
    send_point(aimed_point(211, 161, 1'b0));
    send_point(aimed_point(429, 319, 1'b0));
    send_point(aimed_point(200, 150, 1'b0));
    send_point(aimed_point(440, 330, 1'b0));
    send_point(aimed_point(320, 240, 1'b1));
    // Cloud with nothing kept: publish must stay low.
    send_point(aimed_point(0, 0, 1'b0));
    send_point(make_point(0, 0, 0, 1'b1, 1'b1));
    wait_drained();

    // Box cleared: even a centred point is dropped.
    program_box(100, 80, 540, 400, 1'b0);
    send_point(make_point(0, 0, ONE_METRE, 1'b1, 1'b0));
    send_point(aimed_point(320, 240, 1'b1));
    wait_drained();

    // Random phases, one box setting each.
    cloud_left = $urandom_range(1, 24);
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: program_box(-4096, -4096, 4095, 4095, 1'b1);
        1: program_box(4095, 4095, -4096, -4096, 1'b1);
        2: program_box(int'($urandom_range(0, 8191)) - 4096, int'($urandom_range(0, 8191)) - 4096,
                       int'($urandom_range(0, 8191)) - 4096, int'($urandom_range(0, 8191)) - 4096,
                       1'b0);
        3: begin
          bx = $urandom_range(0, 639);
          program_box(bx, 0, bx, 479, 1'b1);
        end
        default: begin
          bx = int'($urandom_range(0, 700)) - 200;
          by = int'($urandom_range(0, 500)) - 200;
          program_box(bx, by, bx + int'($urandom_range(20, 900)),
                      by + int'($urandom_range(20, 700)), 1'b1);
        end
      endcase
      no_idle = (phase == 2) || (phase == 5);

      for (int n = 0; n < PHASE_POINTS; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 70)
          p = aimed_point(int'($urandom_range(0, 760)) - 60, int'($urandom_range(0, 600)) - 60,
                          cloud_left == 1);
        else if (sel < 85)
          p = make_point(longint'($signed($urandom)), longint'($signed($urandom)),
                         longint'($signed($urandom)), $urandom_range(0, 1), cloud_left == 1);
        else
          p = edge_point(cloud_left == 1);
        send_point(p);
        if (cloud_left == 1) cloud_left = $urandom_range(1, 24);
        else cloud_left--;
        // Now and then starve the block completely before going on.
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
      wait_drained();
    end

    no_idle = 1'b0;
    $display("covered %0d points in %0d clouds under %0d box settings:", points_sent,
             clouds_sent, box_settings);
    $display("  extremes, zero depth, non-finite, box cleared, inverted and degenerate boxes");
    if (mismatches == 0 && pending == 0) begin
      $display("pinhole_roi_point_filter: match");
    end else begin
      $display("pinhole_roi_point_filter: mismatch");
    end
    $finish;
  end

endmodule
